/* design/binary_to_decimal_ascii_unit_macros.svh */
// assertion macros for the binary to decimal ascii unit checker
// no dependencies; expects a signal named clock and one named reset in scope
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define BDAU_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("bdau check failed");

// condition implies consequence in the next cycle
`define BDAU_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("bdau check failed");

`endif

/* design/bdau_pkg.sv */
// shared types and constants of the binary to decimal ascii unit
// no dependencies
`default_nettype none

package bdau_pkg;

   localparam int VALUE_W     = 32;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 6;
   localparam int FULL_DIGITS = 10;
   localparam int BIT_COUNT_W = 5;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // one queued request, classified by the front
   typedef struct packed {
      logic               zero;
      logic [VALUE_W-1:0] value;
   } item_type;

   // queue head as seen by the back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

`default_nettype wire

/* design/bdau_front.sv */
// front of the binary to decimal ascii unit: accepts requests into a two-entry queue
// depends on bdau_pkg
`default_nettype none

module bdau_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [bdau_pkg::VALUE_W-1:0] req_value,
   output bdau_pkg::queue_head_type          head,
   input  wire logic                         head_ready
);

   bdau_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   // queue control
   always_comb begin
      req_ready  = (count_ff != 2'd2);
      push       = req_valid && req_ready;
      head.valid = (count_ff != 2'd0);
      head.item  = slot_ff[rd_ptr_ff];
      pop        = head.valid && head_ready;
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // pointers, count and classified slots
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff].zero  <= (req_value == '0);
         slot_ff[wr_ptr_ff].value <= req_value;
      end
   end

endmodule

`default_nettype wire

/* design/bdau_back.sv */
// back of the binary to decimal ascii unit: double dabble and digit emission
// depends on bdau_pkg
`default_nettype none

module bdau_back #(
   parameter int EMIT_DIGITS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bdau_pkg::queue_head_type    head,
   output logic                             head_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bdau_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                             rsp_last
);

   localparam int BCD_W = EMIT_DIGITS * bdau_pkg::DIGIT_W;
   localparam int IDX_W = (EMIT_DIGITS > 1) ? $clog2(EMIT_DIGITS) : 1;
   localparam logic [bdau_pkg::BIT_COUNT_W-1:0] LAST_BIT =
      bdau_pkg::BIT_COUNT_W'(bdau_pkg::VALUE_W - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_FIND,
      S_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [bdau_pkg::VALUE_W-1:0]      bin_ff, bin_in;
   logic [BCD_W-1:0]                  bcd_ff, bcd_in;
   logic [bdau_pkg::BIT_COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic                              ovf_ff, ovf_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bdau_pkg::CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [BCD_W-1:0]                  corr_bcd;
   logic [IDX_W-1:0]                  start_idx;
   logic [bdau_pkg::DIGIT_W-1:0]      cur_digit;
   logic                              out_free;

   // add three to every digit of five or more
   always_comb begin
      for (int i = 0; i < EMIT_DIGITS; i++) begin
         corr_bcd[i*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W] =
            (bcd_ff[i*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W] >= 4'd5)
            ? bcd_ff[i*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W] + 4'd3
            : bcd_ff[i*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W];
      end
   end

   // highest nonzero digit, zero when all digits are zero
   always_comb begin
      start_idx = '0;
      for (int i = 0; i < EMIT_DIGITS; i++) begin
         if (bcd_ff[i*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W] != '0) begin
            start_idx = IDX_W'(i);
         end
      end
   end

   assign cur_digit  = bcd_ff[idx_ff*bdau_pkg::DIGIT_W +: bdau_pkg::DIGIT_W];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign head_ready = (state_ff == S_IDLE);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               bin_in   = head.item.value;
               bcd_in   = '0;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = head.item.zero ? S_FIND : S_CONV;
            end
         end
         S_CONV: begin
            bcd_in = {corr_bcd[BCD_W-2:0], bin_ff[bdau_pkg::VALUE_W-1]};
            bin_in = {bin_ff[bdau_pkg::VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            // a carry out of the top kept digit means higher digits exist
            ovf_in = ovf_ff || corr_bcd[BCD_W-1];
            if (cnt_ff == LAST_BIT) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            // with dropped upper digits every kept slot is emitted
            idx_in   = ovf_ff ? IDX_W'(EMIT_DIGITS - 1) : start_idx;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = bdau_pkg::ASCII_ZERO + {2'b00, cur_digit};
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      ovf_ff      <= ovf_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

/* design/binary_to_decimal_ascii_unit.sv */
// top level of the binary to decimal ascii unit
// depends on bdau_pkg, bdau_front and bdau_back
//
// Usage: a request carries one 32-bit unsigned value on req_value (valid/ready).
// For each request the rsp channel (valid/ready) returns its decimal digits as
// ASCII codes, most significant first, no leading zeros, rsp_last on the final
// digit; zero gives a single '0'. With MAX_DIGITS below ten only the lowest
// MAX_DIGITS digits are returned.
// A two-entry request queue sits in front of the converter, so requests are
// taken while an earlier value is still converting or its digits are stalled.
// Sequence: a nonzero value passes through the bit-serial double dabble loop
// (one input bit per cycle), then a step that finds the top digit, then digit
// emission. A zero value skips the shift loop. The converter finishes one
// value before it takes the next from the queue.
// When rsp_ready is low the current digit holds in the output register and
// the digit emission waits; the queue keeps taking requests until it is full.
// Reset (synchronous, active high) empties the queue and drops any work.
`default_nettype none

module binary_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [bdau_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [bdau_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                              rsp_last
);

   // digits kept by the converter: a 32-bit value never needs more than ten
   localparam int EMIT_DIGITS =
      (MAX_DIGITS < bdau_pkg::FULL_DIGITS) ? MAX_DIGITS : bdau_pkg::FULL_DIGITS;

   bdau_pkg::queue_head_type head;
   logic                     head_ready;

   // request queue
   bdau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .head       (head),
      .head_ready (head_ready)
   );

   // converter and digit output
   bdau_back #(
      .EMIT_DIGITS (EMIT_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_ready     (head_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* design/bdau_checker.sv */
// port-level checks for the binary to decimal ascii unit, bound to the top level
// depends on binary_to_decimal_ascii_unit_macros.svh and bdau_pkg
`default_nettype none
`include "binary_to_decimal_ascii_unit_macros.svh"

module bdau_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic [bdau_pkg::VALUE_W-1:0] req_value,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [bdau_pkg::CHAR_W-1:0]  rsp_digit_char,
   input wire logic                         rsp_last
);

   // stalled digit holds
   `BDAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))

   // every emitted code is a decimal digit
   `BDAU_ASSERT_SAME(a_rsp_digit, rsp_valid, (rsp_digit_char >= 6'd48) && (rsp_digit_char <= 6'd57))

   // nothing is presented straight out of reset
   `BDAU_ASSERT_SAME(a_rsp_after_reset, $past(reset), !rsp_valid && (req_valid || !req_valid || (req_value == req_value)))

   // the queue is open right after reset
   `BDAU_ASSERT_SAME(a_req_after_reset, $past(reset), req_ready)

endmodule

bind binary_to_decimal_ascii_unit bdau_checker u_bdau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last)
);

`default_nettype wire

/* tb/sv/tb_binary_to_decimal_ascii_unit.sv */
// self-checking testbench for binary_to_decimal_ascii_unit: directed table, then random values
// depends on bdau_pkg and the binary_to_decimal_ascii_unit rtl
module tb_binary_to_decimal_ascii_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGIT_SLOTS    = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_COUNT   = 440;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int DIRECTED_COUNT = 20;
   localparam int STALL_WINDOW   = 97;

   typedef struct packed {
      logic [bdau_pkg::CHAR_W-1:0] digit_char;
      logic                        last;
   } digit_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_LONG_STALL
   } stall_mode_type;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [bdau_pkg::VALUE_W-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [bdau_pkg::CHAR_W-1:0]  rsp_digit_char;
   logic                         rsp_last;

   // digits still owed by the block, oldest first
   digit_result_type expected_digits[$];
   // typed-in text of the request on the bus, empty when the predictor decides
   string         pending_text = "";
   int            error_count  = 0;
   int            idle_cycles  = 0;
   int            burst_left   = 0;

   stall_mode_type  stall_mode    = READY_ALWAYS;
   int              window_pos    = 0;
   logic [15:0]     stall_pattern = 16'hFFFF;

   // directed table: extremes, digit-count boundaries, bit patterns
   logic [bdau_pkg::VALUE_W-1:0] directed_value [DIRECTED_COUNT] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
      32'd4294967295, 32'd0, 32'd4294967294, 32'h80000000, 32'h7FFFFFFF,
      32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 32'hFFFF0000, 32'd12345678,
      32'd1000000001, 32'd65536
   };
   string directed_text [DIRECTED_COUNT] = '{
      "0", "1", "9", "10", "99", "100", "999999999", "1000000000",
      "4294967295", "0", "4294967294", "", "", "", "", "", "", "", "", ""
   };

   binary_to_decimal_ascii_unit #(
      .MAX_DIGITS(DIGIT_SLOTS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // decimal digits of one value, most significant first, lowest slots kept
   function automatic void predict_digits(input logic [bdau_pkg::VALUE_W-1:0] value);
      logic [bdau_pkg::VALUE_W-1:0] rest;
      int                           low_digits [DIGIT_SLOTS];
      int                           count;
      rest  = value;
      count = 0;
      if (rest == '0) begin
         expected_digits.push_back('{digit_char: bdau_pkg::ASCII_ZERO, last: 1'b1});
         return;
      end
      while (rest != '0 && count < DIGIT_SLOTS) begin
         low_digits[count] = int'(rest % 10);
         rest              = rest / 10;
         count++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         expected_digits.push_back(
            '{digit_char: bdau_pkg::ASCII_ZERO + bdau_pkg::CHAR_W'(low_digits[i]),
              last: (i == 0)});
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // one request: raise valid at the falling edge, hold until accepted
   task automatic send_value(input logic [bdau_pkg::VALUE_W-1:0] value, input string text);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_value    <= value;
      pending_text  = text;
      do @(posedge clock); while (!req_ready);
   endtask

   // bursts of requests with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // stop sending until every owed digit has come back
   task automatic drain_digits();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern, re-chosen every window
   always @(negedge clock) begin : receiver_stall
      logic ready_next;
      if (window_pos == 0) begin
         stall_mode    = stall_mode_type'($urandom_range(0, 3));
         stall_pattern = 16'($urandom);
      end
      case (stall_mode)
         READY_ALWAYS:     ready_next = 1'b1;
         READY_RANDOM:     ready_next = 1'($urandom_range(0, 1));
         READY_PATTERN:    ready_next = stall_pattern[window_pos % 16];
         READY_LONG_STALL: ready_next = (window_pos >= 40);
         default:          ready_next = 1'b1;
      endcase
      window_pos = (window_pos + 1) % STALL_WINDOW;
      rsp_ready <= ready_next;
   end

   // compare digits, record requests, watch for a stuck block
   always @(posedge clock) begin : check_digits
      digit_result_type oldest;
      logic             progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("digit 0x%0h last %0b with no value pending",
                                         rsp_digit_char, rsp_last));
            end else begin
               oldest = expected_digits.pop_front();
               if (rsp_digit_char !== oldest.digit_char)
                  report_mismatch($sformatf("digit_char got %0d want %0d",
                                            rsp_digit_char, oldest.digit_char));
               if (rsp_last !== oldest.last)
                  report_mismatch($sformatf("last got %0b want %0b",
                                            rsp_last, oldest.last));
            end
         end
         if (req_valid && req_ready) begin
            progress = 1'b1;
            if (pending_text.len() == 0) begin
               predict_digits(req_value);
            end else begin
               for (int i = 0; i < pending_text.len(); i++) begin
                  expected_digits.push_back(
                     '{digit_char: bdau_pkg::CHAR_W'(pending_text[i]),
                       last: (i == pending_text.len() - 1)});
               end
            end
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d digits owed",
                     IDLE_LIMIT, expected_digits.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // stimulus: reset, directed table, random values, drain
   initial begin : stimulus
      logic [bdau_pkg::VALUE_W-1:0] value;
      logic [bdau_pkg::VALUE_W-1:0] power;
      int                           shape;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         pace_sender();
         send_value(directed_value[i], directed_text[i]);
      end
      drain_digits();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 2) drain_digits();
         shape = $urandom_range(0, 9);
         case (shape) inside
            [0:3]:   value = $urandom;
            [4:5]:   value = $urandom >> $urandom_range(0, 31);
            6: begin
               // just around a power of ten, where the digit count changes
               power = 1;
               repeat ($urandom_range(0, 9)) power = power * 10;
               value = power + bdau_pkg::VALUE_W'($urandom_range(0, 2)) - 1;
            end
            7:       value = '0;
            8:       value = bdau_pkg::VALUE_W'($urandom_range(0, 99));
            default: value = 32'hFFFFFFFF - bdau_pkg::VALUE_W'($urandom_range(0, 1000));
         endcase
         pace_sender();
         send_value(value, "");
      end

      drain_digits();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* binary_to_decimal_ascii_unit.f */
+incdir+design
design/bdau_pkg.sv
design/bdau_front.sv
design/bdau_back.sv
design/binary_to_decimal_ascii_unit.sv
design/bdau_checker.sv
tb/sv/tb_binary_to_decimal_ascii_unit.sv
